### rtl/core/mcol_pkg.sv
// Shared constants and codes for the midpoint circle outline unit.
`timescale 1ns / 1ps
`default_nettype none
package mcol_pkg;

	localparam int PIX_W     = 14;
	localparam int COLOR_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int OCT_W     = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X   = 2'd0,
		REG_CENTER_Y   = 2'd1,
		REG_RADIUS     = 2'd2,
		REG_DRAW_COLOR = 2'd3
	} cfg_reg_t;

endpackage
`default_nettype wire

### rtl/core/midpoint_circle_outline_unit.sv
// Top level of the midpoint circle outline unit: configuration registers and stream ports.
`timescale 1ns / 1ps
`default_nettype none
// Each input transfer carries start_new: 1 begins a circle from the configured radius, 0 advances
// the octant walk by one step (ignored when no circle is in progress). Every step yields eight
// output transfers, one mirrored pixel per cycle while m_tready holds, from the single pixel output
// register. A two-entry step queue sits between the walk and the pixel expander, so input
// transfers are taken back to back until it fills. A step passes through the queue entry, the
// back-end step registers and the pixel output register. Centre and colour are sampled as each
// pixel is formed; radius only on a start. Coordinates are unclipped two's complement.
module midpoint_circle_outline_unit
	import mcol_pkg::*;
#(
	parameter int RADIUS_BITS = 11,
	parameter int COORD_BITS  = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // [0] start_new
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [63:0]               m_tdata,   // [13:0] pixel_x, [27:14] pixel_y, [59:28] pixel_value
	output logic                      m_tlast,   // step_last
	output logic                      m_tuser,   // [0] circle_done
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COLOR_W-1:0]   cfg_wdata
);

	localparam int OFF_W = RADIUS_BITS + 2;
	localparam int ENT_W = 2 * OFF_W + 1;

	logic [COORD_BITS-1:0]  center_x_q, center_y_q;
	logic [RADIUS_BITS-1:0] radius_q;
	logic [COLOR_W-1:0]     draw_color_q;

	logic             push, pop, q_full, q_valid;
	logic [ENT_W-1:0] push_data, q_data;
	logic [PIX_W-1:0] pix_x, pix_y;
	logic [COLOR_W-1:0] pix_color;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q   <= '0;
			center_y_q   <= '0;
			radius_q     <= '0;
			draw_color_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:   center_x_q   <= cfg_wdata[COORD_BITS-1:0];
				REG_CENTER_Y:   center_y_q   <= cfg_wdata[COORD_BITS-1:0];
				REG_RADIUS:     radius_q     <= cfg_wdata[RADIUS_BITS-1:0];
				REG_DRAW_COLOR: draw_color_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	mcol_front #(
		.RADIUS_BITS (RADIUS_BITS),
		.OFF_W       (OFF_W),
		.ENT_W       (ENT_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_tvalid),
		.item_start (s_tdata[0]),
		.item_ready (s_tready),
		.radius     (radius_q),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	mcol_queue #(
		.ENT_W (ENT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_data    (q_data)
	);

	mcol_back #(
		.COORD_BITS (COORD_BITS),
		.OFF_W      (OFF_W),
		.ENT_W      (ENT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.pop        (pop),
		.center_x   (center_x_q),
		.center_y   (center_y_q),
		.draw_color (draw_color_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_x      (pix_x),
		.out_y      (pix_y),
		.out_color  (pix_color),
		.out_last   (m_tlast),
		.out_done   (m_tuser)
	);

	assign m_tdata = {4'b0, pix_color, pix_y, pix_x};

endmodule
`default_nettype wire

### rtl/core/mcol_front.sv
// Front end: takes items, runs the octant walk; one step per start or active advance.
`timescale 1ns / 1ps
`default_nettype none
module mcol_front #(
	parameter int RADIUS_BITS = 11,
	parameter int OFF_W       = RADIUS_BITS + 2,
	parameter int ENT_W       = 2 * OFF_W + 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	input  wire logic                   item_start,
	output logic                        item_ready,
	input  wire logic [RADIUS_BITS-1:0] radius,
	input  wire logic                   q_full,
	output logic                        push,
	output logic [ENT_W-1:0]            push_data
);

	localparam int DEC_W = RADIUS_BITS + 5;

	logic signed [OFF_W-1:0] x_q, y_q;
	logic signed [DEC_W-1:0] d_q;
	logic                    active_q;

	logic                    accept;
	logic signed [OFF_W-1:0] x_nx, y_nx;
	logic signed [DEC_W-1:0] d_nx, d_init, d_inc;
	logic signed [OFF_W:0]   diff;
	logic                    done_nx;

	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;
	assign push       = accept && (item_start || active_q);

	// 3 - 2r
	assign d_init = DEC_W'(3) - $signed({{(DEC_W-RADIUS_BITS-1){1'b0}}, radius, 1'b0});

	always_comb begin
		x_nx  = x_q + OFF_W'(1);
		y_nx  = y_q;
		diff  = '0;
		d_inc = '0;
		d_nx  = d_q;
		if (item_start) begin
			x_nx = '0;
			y_nx = $signed({{(OFF_W-RADIUS_BITS){1'b0}}, radius});
			d_nx = d_init;
		end else if (d_q > 0) begin
			y_nx  = y_q - OFF_W'(1);
			diff  = (OFF_W+1)'(x_nx) - (OFF_W+1)'(y_nx);
			d_inc = (DEC_W'(diff) <<< 2) + DEC_W'(10);
			d_nx  = d_q + d_inc;
		end else begin
			d_inc = (DEC_W'(x_nx) <<< 2) + DEC_W'(6);
			d_nx  = d_q + d_inc;
		end
	end

	assign done_nx   = y_nx < x_nx;
	assign push_data = {done_nx, y_nx, x_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			d_q      <= '0;
			active_q <= 1'b0;
		end else if (push) begin
			x_q      <= x_nx;
			y_q      <= y_nx;
			d_q      <= d_nx;
			active_q <= !done_nx;
		end
	end

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(push && done_nx) |=> !active_q)
		else $error("walk still active after final step");
	a_idle_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !item_start && !active_q) |-> !push)
		else $error("advance while idle produced a step");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("step pushed into full queue");

endmodule
`default_nettype wire

### rtl/core/mcol_queue.sv
// Two-entry step queue between the walk front end and the pixel back end.
`timescale 1ns / 1ps
`default_nettype none
module mcol_queue #(
	parameter int ENT_W = 27
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [ENT_W-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  q_valid,
	output logic [ENT_W-1:0]      q_data
);

	localparam int DEPTH = 2;

	logic [ENT_W-1:0] mem_q [DEPTH];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;

	assign full    = count_q == 2'(DEPTH);
	assign q_valid = count_q != '0;
	assign q_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(DEPTH))
		else $error("queue count out of range");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == 2'(DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

### rtl/core/mcol_back.sv
// Back end: expands each walk step into eight mirrored pixels, one per cycle unless the output stalls.
`timescale 1ns / 1ps
`default_nettype none
module mcol_back
	import mcol_pkg::*;
#(
	parameter int COORD_BITS = 12,
	parameter int OFF_W      = 13,
	parameter int ENT_W      = 2 * OFF_W + 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire logic [ENT_W-1:0]      q_data,
	output logic                       pop,
	input  wire logic [COORD_BITS-1:0] center_x,
	input  wire logic [COORD_BITS-1:0] center_y,
	input  wire logic [COLOR_W-1:0]    draw_color,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [PIX_W-1:0]           out_x,
	output logic [PIX_W-1:0]           out_y,
	output logic [COLOR_W-1:0]         out_color,
	output logic                       out_last,
	output logic                       out_done
);

	localparam int CALC_A = (COORD_BITS + 2 > OFF_W + 1) ? COORD_BITS + 2 : OFF_W + 1;
	localparam int CALC_W = (CALC_A > PIX_W) ? CALC_A : PIX_W;

	logic signed [OFF_W-1:0] x_q, y_q;
	logic                    done_q;
	logic                    busy_q;
	logic [OCT_W-1:0]        k_q;

	logic                     adv, last_pix;
	logic signed [OFF_W-1:0]  a_off, b_off;
	logic signed [CALC_W-1:0] cx_w, cy_w, a_w, b_w, px, py;

	assign last_pix = k_q == '1;
	assign adv      = busy_q && (!out_valid || out_ready);
	assign pop      = q_valid && (!busy_q || (adv && last_pix));

	// bit 2 swaps the roles of x and y, bit 0 mirrors horizontally, bit 1 vertically
	always_comb begin
		a_off = k_q[2] ? y_q : x_q;
		b_off = k_q[2] ? x_q : y_q;
		cx_w  = $signed({{(CALC_W-COORD_BITS){1'b0}}, center_x});
		cy_w  = $signed({{(CALC_W-COORD_BITS){1'b0}}, center_y});
		a_w   = CALC_W'(a_off);
		b_w   = CALC_W'(b_off);
		px    = k_q[0] ? cx_w - a_w : cx_w + a_w;
		py    = k_q[1] ? cy_w - b_w : cy_w + b_w;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q    <= q_data[OFF_W-1:0];
			y_q    <= q_data[2*OFF_W-1:OFF_W];
			done_q <= q_data[ENT_W-1];
		end
		if (adv) begin
			out_x     <= px[PIX_W-1:0];
			out_y     <= py[PIX_W-1:0];
			out_color <= draw_color;
			out_last  <= last_pix;
			out_done  <= last_pix && done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			k_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (adv) begin
				k_q <= k_q + OCT_W'(1);
				if (last_pix)
					busy_q <= 1'b0;
			end
			if (adv)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_done) |-> out_last)
		else $error("circle_done without step_last");
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (k_q == '0))
		else $error("pixel counter moved while idle");
	a_pop_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && busy_q) |-> (adv && last_pix))
		else $error("new step loaded before current step finished");

endmodule
`default_nettype wire
